### design/brute_force_knn_point_store_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the brute-force k-nearest-neighbor point store.
// Both macros expect signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef BRUTE_FORCE_KNN_POINT_STORE_DEFINES_SVH
`define BRUTE_FORCE_KNN_POINT_STORE_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BFKNN_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Checks that a consequent holds whenever an antecedent holds.
`define BFKNN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/bfknn_pkg.sv
// ----------------------------------------------------------------------------
// bfknn_pkg
// Shared types, codes and default sizes of the k-nearest-neighbor point store.
// ----------------------------------------------------------------------------
package bfknn_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int K_MAX_DEF       = 8;

  localparam int COORD_W      = 16;
  localparam int DIST_W       = 34;
  localparam int PIDX_W       = 8;
  localparam int NC_W         = 4;
  localparam int IN_TDATA_W   = 2 * COORD_W;
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_USED_W   = 1 + PIDX_W + DIST_W;

  localparam logic [NC_W-1:0] NC_RESET = NC_W'(1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic STATUS_STORED  = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_NEIGHBOR = 2'd1,
    KIND_NONE     = 2'd2
  } kind_t;

endpackage

### design/bfknn_ram.sv
// ----------------------------------------------------------------------------
// bfknn_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module bfknn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/brute_force_knn_point_store.sv
// ----------------------------------------------------------------------------
// brute_force_knn_point_store: inserts and k-nearest-neighbor queries, 2D.
// Insert or empty query: one registered result; input waits until it is loaded.
// Query, n results: scans one point a cycle, then emits the n nearest in order.
// Synchronous reset empties the store and sets neighbor_count to 1.
// ----------------------------------------------------------------------------
`include "brute_force_knn_point_store_defines.svh"

module brute_force_knn_point_store #(
  parameter int STORE_DEPTH = bfknn_pkg::STORE_DEPTH_DEF,
  parameter int K_MAX       = bfknn_pkg::K_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration: neighbor_count.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfknn_pkg::NC_W-1:0]         cfg_data,
  // Input: tdata = x_coord[15:0], y_coord[31:16]; tuser = mode.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bfknn_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                               in_tuser,
  // Output: tdata = status[0], point_index[8:1], dist_sq[42:9], zeros above.
  // tuser = kind; tlast = last.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bfknn_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast
);

  import bfknn_pkg::*;

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int KW = $clog2(K_MAX + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RESP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [NC_W-1:0] nc_r, nc_nxt;
  logic [CW-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic            v1_r, v2_r, v3_r, v4_r;
  logic [K_MAX-1:0] valid_r, valid_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [KW-1:0]          kn_r, kn_nxt;
  logic [COORD_W-1:0]     qx_r, qy_r;
  kind_t                  resp_kind_r, resp_kind_nxt;
  logic                   resp_status_r, resp_status_nxt;
  logic [PIDX_W-1:0]      resp_idx_r, resp_idx_nxt;
  logic [IW-1:0]          idx1_r, idx2_r, idx3_r, idx4_r;
  logic [COORD_W-1:0]     ax2_r, ay2_r;
  logic [2*COORD_W-1:0]   sqx3_r, sqy3_r;
  logic [DIST_W-1:0]      d4_r;
  logic [DIST_W-1:0]      best_d_r [K_MAX];
  logic [DIST_W-1:0]      best_d_nxt [K_MAX];
  logic [IW-1:0]          best_idx_r [K_MAX];
  logic [IW-1:0]          best_idx_nxt [K_MAX];

  kind_t             out_kind_r, out_kind_nxt;
  logic              out_status_r, out_status_nxt;
  logic [PIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_last_r, out_last_nxt;

  logic                 in_acc, slot_free, issue, full, emit_last, pipe_busy;
  logic                 wr_en;
  logic [IN_TDATA_W-1:0] rd_data;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]   ax, ay;
  logic [K_MAX-1:0]     lt, ahead;
  logic [K_MAX:0]       valid_ext;
  logic [DIST_W-1:0]    prev_d [K_MAX];
  logic [IW-1:0]        prev_idx [K_MAX];
  logic [K_MAX-1:0]     prev_valid;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign full      = (count_r == CW'(STORE_DEPTH));
  assign issue     = (state_r == ST_SCAN) && (scan_cnt_r < count_r);
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;
  assign wr_en     = in_acc && (in_tuser == MODE_INSERT) && !full;
  assign valid_ext = {1'b0, valid_r};
  assign emit_last = !valid_ext[1];

  bfknn_ram #(
    .WIDTH(IN_TDATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[IW-1:0]),
    .wr_data(in_tdata),
    .rd_en  (issue),
    .rd_addr(scan_cnt_r[IW-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    dx = $signed({rd_data[COORD_W-1], rd_data[COORD_W-1:0]})
       - $signed({qx_r[COORD_W-1], qx_r});
    dy = $signed({rd_data[IN_TDATA_W-1], rd_data[IN_TDATA_W-1:COORD_W]})
       - $signed({qy_r[COORD_W-1], qy_r});
    ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      lt[i] = valid_r[i] && (best_d_r[i] <= d4_r);
    end
    ahead[0]      = 1'b1;
    prev_d[0]     = d4_r;
    prev_idx[0]   = idx4_r;
    prev_valid[0] = 1'b1;
    for (int i = 1; i < K_MAX; i++) begin
      ahead[i]      = lt[i-1];
      prev_d[i]     = best_d_r[i-1];
      prev_idx[i]   = best_idx_r[i-1];
      prev_valid[i] = valid_r[i-1];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    nc_nxt          = nc_r;
    scan_cnt_nxt    = scan_cnt_r;
    valid_nxt       = valid_r;
    kn_nxt          = kn_r;
    resp_kind_nxt   = resp_kind_r;
    resp_status_nxt = resp_status_r;
    resp_idx_nxt    = resp_idx_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_idx_nxt     = out_idx_r;
    out_dist_nxt    = out_dist_r;
    out_last_nxt    = out_last_r;
    for (int i = 0; i < K_MAX; i++) begin
      best_d_nxt[i]   = best_d_r[i];
      best_idx_nxt[i] = best_idx_r[i];
    end

    if (cfg_valid && cfg_ready) begin
      nc_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == MODE_INSERT) begin
            resp_kind_nxt = KIND_ACK;
            state_nxt     = ST_RESP;
            if (full) begin
              resp_status_nxt = STATUS_REFUSED;
              resp_idx_nxt    = '0;
            end else begin
              resp_status_nxt = STATUS_STORED;
              resp_idx_nxt    = PIDX_W'(count_r);
              count_nxt       = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            resp_kind_nxt   = KIND_NONE;
            resp_status_nxt = STATUS_STORED;
            resp_idx_nxt    = '0;
            state_nxt       = ST_RESP;
          end else begin
            if (nc_r == '0) begin
              kn_nxt = KW'(1);
            end else if (32'(nc_r) > K_MAX) begin
              kn_nxt = KW'(K_MAX);
            end else begin
              kn_nxt = KW'(nc_r);
            end
            valid_nxt    = '0;
            scan_cnt_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = resp_kind_r;
          out_status_nxt = resp_status_r;
          out_idx_nxt    = resp_idx_r;
          out_dist_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end
        if (v4_r) begin
          for (int i = 0; i < K_MAX; i++) begin
            if ((KW'(i) < kn_r) && !lt[i]) begin
              if (ahead[i]) begin
                best_d_nxt[i]   = d4_r;
                best_idx_nxt[i] = idx4_r;
                valid_nxt[i]    = 1'b1;
              end else begin
                best_d_nxt[i]   = prev_d[i];
                best_idx_nxt[i] = prev_idx[i];
                valid_nxt[i]    = prev_valid[i];
              end
            end
          end
        end
        if (!issue && !pipe_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_NEIGHBOR;
          out_status_nxt = STATUS_STORED;
          out_idx_nxt    = PIDX_W'(best_idx_r[0]);
          out_dist_nxt   = best_d_r[0];
          out_last_nxt   = emit_last;
          for (int i = 0; i < K_MAX - 1; i++) begin
            best_d_nxt[i]   = best_d_r[i+1];
            best_idx_nxt[i] = best_idx_r[i+1];
          end
          valid_nxt = valid_ext[K_MAX:1];
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      nc_r        <= NC_RESET;
      scan_cnt_r  <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      nc_r        <= nc_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kn_r          <= kn_nxt;
    resp_kind_r   <= resp_kind_nxt;
    resp_status_r <= resp_status_nxt;
    resp_idx_r    <= resp_idx_nxt;
    if (in_acc) begin
      qx_r <= in_tdata[COORD_W-1:0];
      qy_r <= in_tdata[IN_TDATA_W-1:COORD_W];
    end
    idx1_r <= scan_cnt_r[IW-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    ax2_r  <= ax;
    ay2_r  <= ay;
    sqx3_r <= ax2_r * ax2_r;
    sqy3_r <= ay2_r * ay2_r;
    d4_r   <= DIST_W'({1'b0, sqx3_r} + {1'b0, sqy3_r});
    for (int i = 0; i < K_MAX; i++) begin
      best_d_r[i]   <= best_d_nxt[i];
      best_idx_r[i] <= best_idx_nxt[i];
    end
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_dist_r   <= out_dist_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_dist_r, out_idx_r,
                       out_status_r};

  `BFKNN_ASSERT(a_valid_prefix, (valid_r & (valid_r + K_MAX'(1))) == '0, "neighbor list has a hole")
  `BFKNN_ASSERT_IMP(a_emit_nonempty, state_r == ST_EMIT, valid_r[0], "emitting from an empty list")
  `BFKNN_ASSERT(a_count_bound, count_r <= CW'(STORE_DEPTH), "store count beyond depth")
  `BFKNN_ASSERT_IMP(a_pipe_in_scan, pipe_busy, state_r == ST_SCAN, "distance pipeline busy outside a scan")

endmodule

### bench/brute_force_knn_point_store_checker.sv
// ----------------------------------------------------------------------------
// brute_force_knn_point_store_checker
// Watches the configuration, point and result channels of the point store,
// keeps its own copy of the stored points and the neighbor count, predicts
// the results of every accepted transaction and compares each result field
// by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module brute_force_knn_point_store_checker #(
  parameter int STORE_DEPTH = bfknn_pkg::STORE_DEPTH_DEF,
  parameter int K_MAX       = bfknn_pkg::K_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bfknn_pkg::NC_W-1:0]        cfg_data,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [bfknn_pkg::IN_TDATA_W-1:0]  in_tdata,   // x_coord, y_coord
  input  logic                              in_tuser,   // mode
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [bfknn_pkg::OUT_TDATA_W-1:0] out_tdata,  // status, point_index, dist_sq
  input  logic [1:0]                        out_tuser,  // kind
  input  logic                              out_tlast,
  output int                                fail_count,
  output int                                outstanding
);

  import bfknn_pkg::*;

  typedef struct {
    kind_t              kind;
    logic               status;
    logic [PIDX_W-1:0]  point_index;
    logic [DIST_W-1:0]  dist_sq;
    logic               last;
  } knn_result_t;

  logic signed [COORD_W-1:0] pt_x [STORE_DEPTH];
  logic signed [COORD_W-1:0] pt_y [STORE_DEPTH];
  int                        pt_count;
  logic [NC_W-1:0]           k_setting;
  knn_result_t               expected_results [$];
  int                        errors;

  task automatic push_result(input kind_t kind, input logic status,
                             input logic [PIDX_W-1:0] idx,
                             input logic [DIST_W-1:0] dist_val, input logic last);
    knn_result_t r;
    r.kind        = kind;
    r.status      = status;
    r.point_index = idx;
    r.dist_sq     = dist_val;
    r.last        = last;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_insert(input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y);
    if (pt_count >= STORE_DEPTH) begin
      push_result(KIND_ACK, STATUS_REFUSED, '0, '0, 1'b1);
    end else begin
      pt_x[pt_count] = x;
      pt_y[pt_count] = y;
      push_result(KIND_ACK, STATUS_STORED, PIDX_W'(pt_count), '0, 1'b1);
      pt_count++;
    end
  endtask

  task automatic predict_query(input logic signed [COORD_W-1:0] qx,
                               input logic signed [COORD_W-1:0] qy);
    longint d_sq [STORE_DEPTH];
    bit     taken [STORE_DEPTH];
    longint dx;
    longint dy;
    int     k;
    int     n;
    int     pick;
    if (pt_count == 0) begin
      push_result(KIND_NONE, STATUS_STORED, '0, '0, 1'b1);
    end else begin
      k = int'(k_setting);
      if (k == 0) k = 1;
      if (k > K_MAX) k = K_MAX;
      n = (k < pt_count) ? k : pt_count;
      for (int i = 0; i < pt_count; i++) begin
        dx = longint'(pt_x[i]) - longint'(qx);
        dy = longint'(pt_y[i]) - longint'(qy);
        d_sq[i]  = dx * dx + dy * dy;
        taken[i] = 1'b0;
      end
      // Repeatedly take the nearest point not yet reported; a strict
      // comparison keeps the lower slot ahead when distances are equal.
      for (int rank = 0; rank < n; rank++) begin
        pick = -1;
        for (int i = 0; i < pt_count; i++) begin
          if (!taken[i] && (pick < 0 || d_sq[i] < d_sq[pick])) pick = i;
        end
        taken[pick] = 1'b1;
        push_result(KIND_NEIGHBOR, STATUS_STORED, PIDX_W'(pick),
                    DIST_W'(d_sq[pick]), rank == n - 1);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic check_result();
    knn_result_t e;
    if (expected_results.size() == 0) begin
      $error("result transaction with no prediction waiting: kind %0d", out_tuser);
      errors++;
    end else begin
      e = expected_results.pop_front();
      check_field("kind", 64'(e.kind), 64'(out_tuser));
      check_field("status", 64'(e.status), 64'(out_tdata[0]));
      check_field("point_index", 64'(e.point_index), 64'(out_tdata[PIDX_W:1]));
      check_field("dist_sq", 64'(e.dist_sq), 64'(out_tdata[PIDX_W+DIST_W:PIDX_W+1]));
      check_field("last", 64'(e.last), 64'(out_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pt_count  = 0;
      k_setting = NC_RESET;
      errors    = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) k_setting = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == MODE_QUERY) begin
          predict_query(in_tdata[COORD_W-1:0], in_tdata[2*COORD_W-1:COORD_W]);
        end else begin
          predict_insert(in_tdata[COORD_W-1:0], in_tdata[2*COORD_W-1:COORD_W]);
        end
      end
      if (out_tvalid && out_tready) check_result();
    end
    outstanding <= expected_results.size();
    fail_count  <= errors;
  end

endmodule

### bench/brute_force_knn_point_store_tb.sv
// ----------------------------------------------------------------------------
// brute_force_knn_point_store_tb
// Drives inserts and nearest-neighbor queries into the point store, with a
// directed opening and random phases under varied source and sink pressure,
// changes the neighbor count between phases and reports the verdict.
// ----------------------------------------------------------------------------
module brute_force_knn_point_store_tb;
  import bfknn_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [NC_W-1:0]        cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = MODE_INSERT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  int fail_count;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  brute_force_knn_point_store i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  brute_force_knn_point_store_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_point(input logic mode, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_neighbor_count(input logic [NC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 16)) - 8;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return v[COORD_W-1:0];
  endfunction

  initial begin
    int ins_pct;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(MODE_QUERY, 16'sd0, 16'sd0);
    send_point(MODE_INSERT, -16'sd32768, -16'sd32768);
    send_point(MODE_INSERT, 16'sd32767, 16'sd32767);
    send_point(MODE_INSERT, 16'sd0, 16'sd0);
    send_point(MODE_INSERT, 16'sd32767, -16'sd32768);
    send_point(MODE_INSERT, -16'sd32768, 16'sd32767);
    send_point(MODE_INSERT, 16'sd0, 16'sd0);
    send_point(MODE_INSERT, 16'sd1, -16'sd1);
    send_point(MODE_QUERY, 16'sd32767, 16'sd32767);
    send_point(MODE_QUERY, -16'sd32768, -16'sd32768);
    drain();
    write_neighbor_count(4'd15);
    send_point(MODE_QUERY, 16'sd0, 16'sd0);
    send_point(MODE_QUERY, -16'sd32768, 16'sd32767);
    send_point(MODE_QUERY, 16'sd32767, -16'sd32768);
    drain();
    write_neighbor_count(4'd0);
    send_point(MODE_QUERY, 16'sd0, 16'sd0);
    send_point(MODE_QUERY, 16'sd16, -16'sd16);
    drain();
    write_neighbor_count(4'd8);
    send_point(MODE_QUERY, -16'sd1, 16'sd1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_neighbor_count(4'(K_MAX_DEF));
        end
        1: begin
          send_idle_pct = 65; recv_stall_pct = 0;
          write_neighbor_count(4'd1);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 65;
          write_neighbor_count(4'($urandom_range(0, 15)));
        end
        default: begin
          send_idle_pct = 34; recv_stall_pct = 34;
          write_neighbor_count(4'd15);
        end
      endcase
      ins_pct = (ph == 3) ? 75 : 70;
      for (int i = 0; i < 101; i++) begin
        send_point(($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_QUERY,
                   rand_coord(), rand_coord());
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
